// File: rtl/core/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

  // Frame geometry: address, function, byte count, data words, CRC low, CRC high
  localparam int unsigned REGISTER_COUNT = 7;
  localparam int unsigned SHOWN_WORDS    = 7;
  localparam int unsigned DATA_BYTES     = 2 * REGISTER_COUNT;
  localparam int unsigned FRAME_LEN      = DATA_BYTES + 5;
  localparam int unsigned POS_W          = $clog2(FRAME_LEN + 1);
  localparam int unsigned POS_CRC_LO     = 3 + DATA_BYTES;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] QUIET_MAX = 16'hFFFF;

  localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'h02;
  localparam logic [7:0]  FUNCTION_CODE_RST = 8'h03;
  localparam logic [15:0] GAP_LIMIT_RST     = 16'd400;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_CRC     = 2'd1,
    STATUS_HEADER  = 2'd2,
    STATUS_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDRESS = 2'd0,
    CFG_FUNCTION_CODE = 2'd1,
    CFG_GAP_LIMIT     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] gap_limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
  } step_t;

  typedef struct packed {
    logic    valid;
    status_e status;
  } result_t;

  // CRC-16, reflected, one byte in eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mrc_in_if.sv
`default_nettype none

interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mrc_out_if.sv
`default_nettype none

interface mrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] humidity_tenths;
  logic [15:0] temperature_tenths;
  logic [15:0] conductivity;
  logic [15:0] ph_tenths;
  logic [15:0] nitrogen;
  logic [15:0] phosphorus;
  logic [15:0] potassium;

  modport source (output valid, output status, output humidity_tenths,
                  output temperature_tenths, output conductivity, output ph_tenths,
                  output nitrogen, output phosphorus, output potassium, input ready);
  modport sink (input valid, input status, input humidity_tenths,
                input temperature_tenths, input conductivity, input ph_tenths,
                input nitrogen, input phosphorus, input potassium, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mrc_frame.sv
`default_nettype none

module mrc_frame (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrc_pkg::cfg_t    cfg_i,
  input  mrc_pkg::step_t   step_i,
  output mrc_pkg::result_t result_o,
  output logic [15:0]     held_o [mrc_pkg::REGISTER_COUNT]
);
  import mrc_pkg::*;

  pos_t        pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] quiet_q, quiet_d;
  logic [15:0] quiet_inc;
  logic        open_q, open_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        load_held;
  logic        byte_ok;
  logic [15:0] pending_q [REGISTER_COUNT];
  logic [15:0] held_q [REGISTER_COUNT];

  assign byte_ok   = step_i.valid && (step_i.kind == KIND_BYTE) && open_q;
  assign quiet_inc = (quiet_q != QUIET_MAX) ? quiet_q + 16'd1 : quiet_q;

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    quiet_d   = quiet_q;
    open_d    = open_q;
    hdr_ok_d  = hdr_ok_q;
    crc_lo_d  = crc_lo_q;
    load_held = 1'b0;
    result_o  = '{valid: 1'b0, status: STATUS_VALID};
    if (step_i.valid) begin
      if (step_i.kind == KIND_START) begin
        pos_d    = '0;
        crc_d    = CRC_INIT;
        quiet_d  = '0;
        open_d   = 1'b1;
        hdr_ok_d = 1'b1;
        crc_lo_d = '0;
      end else if (step_i.kind == KIND_TICK && open_q) begin
        quiet_d = quiet_inc;
        if (quiet_inc >= cfg_i.gap_limit) begin
          open_d   = 1'b0;
          result_o = '{valid: 1'b1, status: STATUS_TIMEOUT};
        end
      end else if (byte_ok) begin
        quiet_d = '0;
        pos_d   = pos_q + pos_t'(1);
        if (pos_q < pos_t'(POS_CRC_LO)) begin
          crc_d = crc_feed(crc_q, step_i.data_byte);
          if (pos_q == pos_t'(0) && step_i.data_byte != cfg_i.slave_address) begin
            hdr_ok_d = 1'b0;
          end
          if (pos_q == pos_t'(1) && step_i.data_byte != cfg_i.function_code) begin
            hdr_ok_d = 1'b0;
          end
          if (pos_q == pos_t'(2) && step_i.data_byte != DATA_BYTES[7:0]) begin
            hdr_ok_d = 1'b0;
          end
        end else if (pos_q == pos_t'(POS_CRC_LO)) begin
          crc_lo_d = step_i.data_byte;
        end else begin
          open_d = 1'b0;
          if (!hdr_ok_q) begin
            result_o = '{valid: 1'b1, status: STATUS_HEADER};
          end else if ({step_i.data_byte, crc_lo_q} != crc_q) begin
            result_o = '{valid: 1'b1, status: STATUS_CRC};
          end else begin
            result_o  = '{valid: 1'b1, status: STATUS_VALID};
            load_held = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= CRC_INIT;
      quiet_q  <= '0;
      open_q   <= 1'b0;
      hdr_ok_q <= 1'b1;
      crc_lo_q <= '0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      quiet_q  <= quiet_d;
      open_q   <= open_d;
      hdr_ok_q <= hdr_ok_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // Each data word has fixed frame positions: high byte first, then low byte
  for (genvar j = 0; j < REGISTER_COUNT; j++) begin : g_word
    always_ff @(posedge clk_i) begin
      if (byte_ok && pos_q == pos_t'(3 + 2 * j)) begin
        pending_q[j] <= {step_i.data_byte, 8'h00};
      end else if (byte_ok && pos_q == pos_t'(4 + 2 * j)) begin
        pending_q[j][7:0] <= step_i.data_byte;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        held_q[j] <= '0;
      end else if (load_held) begin
        held_q[j] <= pending_q[j];
      end
    end

    assign held_o[j] = held_q[j];
  end

endmodule

`default_nettype wire

// File: rtl/core/modbus_response_checker.sv
`default_nettype none

// Channel   Dir  Payload                                Word
// in_ch     in   kind[1:0], data_byte[7:0]              start, serial byte or 1 ms tick
// out_ch    out  status[1:0], seven 16-bit held values   one frame verdict
// cfg       in   cfg_we_i, cfg_index_i, cfg_wdata_i     register write, no read-back
//
// One word per cycle sustained while the output register is not stalled.
// The input register feeds the frame logic (CRC-16 over eight unrolled steps, header
// compare, word assembly), which writes the output register when the word advances.
// Reset clears the frame state, held values and both pipeline valids at once.
// A stalled output holds the frame logic; the input register still takes one word.
module modbus_response_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mrc_in_if.sink                        in_ch,
  mrc_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mrc_pkg::*;

  cfg_t        cfg_q;
  logic        in_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        advance;
  step_t       step;
  result_t     result;
  logic        out_valid_q;
  status_e     status_q;
  logic [15:0] held [REGISTER_COUNT];
  logic [15:0] shown [SHOWN_WORDS];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address <= SLAVE_ADDRESS_RST;
      cfg_q.function_code <= FUNCTION_CODE_RST;
      cfg_q.gap_limit     <= GAP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLAVE_ADDRESS: cfg_q.slave_address <= cfg_wdata_i[7:0];
        CFG_FUNCTION_CODE: cfg_q.function_code <= cfg_wdata_i[7:0];
        CFG_GAP_LIMIT:     cfg_q.gap_limit     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Advance the held word into the frame logic whenever the output register can take
  // its result; the input register refills in the same edge.
  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_q <= in_ch.kind;
      byte_q <= in_ch.data_byte;
    end
  end

  assign step = '{valid: advance, kind: kind_q, data_byte: byte_q};

  mrc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .step_i   (step),
    .result_o (result),
    .held_o   (held)
  );

  // Output register: drop the verdict once taken, load a new one on advance.
  // Held values change only on advance, so they stay put while a verdict waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.valid;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      status_q <= result.status;
    end
  end

  // Show the first seven held registers; a slot past the register count reads zero
  for (genvar j = 0; j < SHOWN_WORDS; j++) begin : g_shown
    if (j < REGISTER_COUNT) begin : g_used
      assign shown[j] = held[j];
    end else begin : g_zero
      assign shown[j] = '0;
    end
  end

  assign out_ch.valid              = out_valid_q;
  assign out_ch.status             = status_q;
  assign out_ch.humidity_tenths    = shown[0];
  assign out_ch.temperature_tenths = shown[1];
  assign out_ch.conductivity       = shown[2];
  assign out_ch.ph_tenths          = shown[3];
  assign out_ch.nitrogen           = shown[4];
  assign out_ch.phosphorus         = shown[5];
  assign out_ch.potassium          = shown[6];

endmodule

`default_nettype wire

// File: bench/mrc_verdict_monitor.sv
`default_nettype none

module mrc_verdict_monitor
  import mrc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mrc_in_if                     in_ch,
  mrc_out_if                    out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    status_e                      status;
    logic [SHOWN_WORDS-1:0][15:0] words;
  } verdict_t;

  logic [7:0]  want_addr;
  logic [7:0]  want_func;
  logic [15:0] gap_lim;

  pos_t        pos;
  logic [15:0] crc;
  logic [15:0] quiet;
  logic        frame_open;
  logic        hdr_ok;
  logic [7:0]  crc_lo;
  logic [15:0] pending_w [REGISTER_COUNT];
  logic [15:0] held_w [REGISTER_COUNT];

  verdict_t verdict_q [$];
  int       mismatches = 0;
  int       outstanding = 0;

  string field_names [SHOWN_WORDS] = '{"humidity_tenths", "temperature_tenths",
    "conductivity", "ph_tenths", "nitrogen", "phosphorus", "potassium"};

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // LSB-first bitwise form of the reflected CRC-16
  function automatic logic [15:0] crc16_shift_in(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void push_verdict(input status_e s);
    verdict_t v;
    v.status = s;
    for (int j = 0; j < SHOWN_WORDS; j++) begin
      v.words[j] = (j < REGISTER_COUNT) ? held_w[j] : 16'h0000;
    end
    verdict_q.push_back(v);
  endfunction

  function automatic void note(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  task automatic take_word(input logic [1:0] k, input logic [7:0] b);
    int off;
    case (k)
      KIND_START: begin
        pos        = '0;
        crc        = CRC_INIT;
        quiet      = '0;
        frame_open = 1'b1;
        hdr_ok     = 1'b1;
        crc_lo     = '0;
      end
      KIND_TICK: begin
        if (frame_open) begin
          if (quiet != QUIET_MAX) quiet++;
          if (quiet >= gap_lim) begin
            frame_open = 1'b0;
            push_verdict(STATUS_TIMEOUT);
          end
        end
      end
      KIND_BYTE: begin
        if (frame_open) begin
          quiet = '0;
          if (pos < POS_CRC_LO) begin
            crc = crc16_shift_in(crc, b);
            if (pos == 0) begin
              if (b != want_addr) hdr_ok = 1'b0;
            end else if (pos == 1) begin
              if (b != want_func) hdr_ok = 1'b0;
            end else if (pos == 2) begin
              if (b != 8'(DATA_BYTES)) hdr_ok = 1'b0;
            end else begin
              off = int'(pos) - 3;
              if (off[0] == 1'b0) begin
                pending_w[off >> 1] = {b, 8'h00};
              end else begin
                pending_w[off >> 1][7:0] = b;
              end
            end
            pos++;
          end else if (pos == POS_CRC_LO) begin
            crc_lo = b;
            pos++;
          end else begin
            pos++;
            frame_open = 1'b0;
            if (!hdr_ok) begin
              push_verdict(STATUS_HEADER);
            end else if ({b, crc_lo} != crc) begin
              push_verdict(STATUS_CRC);
            end else begin
              held_w = pending_w;
              push_verdict(STATUS_VALID);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_verdict();
    verdict_t                     want;
    logic [SHOWN_WORDS-1:0][15:0] got;
    got = {out_ch.potassium, out_ch.phosphorus, out_ch.nitrogen, out_ch.ph_tenths,
           out_ch.conductivity, out_ch.temperature_tenths, out_ch.humidity_tenths};
    if (verdict_q.size() == 0) begin
      note($sformatf("verdict with none outstanding, status %0d", out_ch.status));
    end else begin
      want = verdict_q.pop_front();
      if (out_ch.status != want.status) begin
        note($sformatf("status: expected %0d got %0d", want.status, out_ch.status));
      end
      for (int j = 0; j < SHOWN_WORDS; j++) begin
        if (got[j] != want.words[j]) begin
          note($sformatf("%s: expected %h got %h", field_names[j], want.words[j], got[j]));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_addr  = SLAVE_ADDRESS_RST;
      want_func  = FUNCTION_CODE_RST;
      gap_lim    = GAP_LIMIT_RST;
      pos        = '0;
      crc        = CRC_INIT;
      quiet      = '0;
      frame_open = 1'b0;
      hdr_ok     = 1'b1;
      crc_lo     = '0;
      for (int j = 0; j < REGISTER_COUNT; j++) begin
        pending_w[j] = '0;
        held_w[j]    = '0;
      end
      verdict_q.delete();
      outstanding = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_verdict();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SLAVE_ADDRESS: want_addr = cfg_wdata_i[7:0];
          CFG_FUNCTION_CODE: want_func = cfg_wdata_i[7:0];
          CFG_GAP_LIMIT:     gap_lim   = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) take_word(in_ch.kind, in_ch.data_byte);
      outstanding = verdict_q.size();
    end
  end

endmodule

`default_nettype wire

// File: bench/modbus_response_checker_tb.sv
`default_nettype none

module modbus_response_checker_tb;
  import mrc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_WORDS  = 230;

  // Kind code that the block has no meaning for
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Ways a generated frame can be spoiled
  typedef enum int {
    FLAW_NONE,
    FLAW_ADDR,
    FLAW_FUNC,
    FLAW_COUNT,
    FLAW_CRC,
    FLAW_SHORT,
    FLAW_RESTART
  } flaw_e;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  cfg_idx_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fails;
  int pending;

  // Stimulus-side copy of the settings, used to build well-formed frames
  logic [7:0]  cur_addr = SLAVE_ADDRESS_RST;
  logic [7:0]  cur_func = FUNCTION_CODE_RST;
  logic [15:0] cur_gap  = GAP_LIMIT_RST;

  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int hold_left   = 0;
  int frame_words = 0;

  mrc_in_if  in_ch ();
  mrc_out_if out_ch ();

  modbus_response_checker i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // Watch both channels and the register port; predict and compare every verdict
  mrc_verdict_monitor i_verdict_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Build frames with the same CRC the far end would append
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Offer one word and hold it until the block takes it. Idle cycles go in
  // front of the word, so valid drops only when a gap is actually wanted.
  task automatic put_word(input logic [1:0] k, input logic [7:0] b, input bit counts = 1'b1);
    while (tx_idle_on && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (counts) frame_words++;
  endtask

  // Write all three registers on back-to-back edges, keeping the enable high
  task automatic load_settings(input logic [7:0] addr, input logic [7:0] func,
                               input logic [15:0] gap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_wdata <= {8'($urandom), addr};   // upper bits must be dropped
    @(posedge clk);
    cfg_index <= CFG_FUNCTION_CODE;
    cfg_wdata <= {8'($urandom), func};
    @(posedge clk);
    cfg_index <= CFG_GAP_LIMIT;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_addr = addr;
    cur_func = func;
    cur_gap  = gap;
  endtask

  // Stop offering, wait for every outstanding verdict, then give the
  // two-stage pipeline time to swallow words that yield no verdict.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // One reply frame: start, header, data, CRC, with the chosen spoiling.
  // Quiet ticks land between bytes, up to one short of the gap limit.
  task automatic send_frame(input flaw_e flaw, input logic [DATA_BYTES-1:0][7:0] data);
    logic [FRAME_LEN-1:0][7:0] body;
    logic [15:0]               sent_crc;
    int                        cut;
    int                        n;
    body[0] = cur_addr;
    body[1] = cur_func;
    body[2] = 8'(DATA_BYTES);
    for (int i = 0; i < DATA_BYTES; i++) body[3 + i] = data[i];
    case (flaw)
      FLAW_ADDR:  body[0] = body[0] ^ 8'($urandom_range(1, 255));
      FLAW_FUNC:  body[1] = body[1] ^ 8'($urandom_range(1, 255));
      FLAW_COUNT: body[2] = body[2] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    sent_crc = CRC_INIT;
    for (int i = 0; i < POS_CRC_LO; i++) sent_crc = crc16_update(sent_crc, body[i]);
    if (flaw == FLAW_CRC) sent_crc = sent_crc ^ (16'(1) << $urandom_range(0, 15));
    body[POS_CRC_LO]     = sent_crc[7:0];
    body[POS_CRC_LO + 1] = sent_crc[15:8];

    cut = FRAME_LEN;
    if (flaw == FLAW_SHORT || flaw == FLAW_RESTART) cut = $urandom_range(0, FRAME_LEN - 1);

    put_word(KIND_START, 8'($urandom));
    for (int i = 0; i < cut; i++) begin
      if (cur_gap >= 16'd2 && $urandom_range(0, 11) == 0) begin
        n = (cur_gap <= 16'd16) ? int'(cur_gap) - 1 : $urandom_range(1, 8);
        repeat (n) put_word(KIND_TICK, 8'($urandom));
      end
      put_word(KIND_BYTE, body[i]);
    end
    // Let the silence run out on a short frame; a restart just walks away
    if (flaw == FLAW_SHORT) begin
      n = (cur_gap == 16'd0) ? 1 : int'(cur_gap);
      repeat (n) put_word(KIND_TICK, 8'($urandom));
    end
  endtask

  // Mostly well-formed frames with random content, the rest spoiled or noise
  task automatic run_random(input int target);
    logic [DATA_BYTES-1:0][7:0] data;
    int                         goal;
    int                         pick;
    goal = frame_words + target;
    while (frame_words < goal) begin
      for (int i = 0; i < DATA_BYTES; i++) data[i] = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        send_frame(FLAW_NONE, data);
      end else if (pick < 64) begin
        pick = $urandom_range(0, 2);
        send_frame((pick == 0) ? FLAW_ADDR : (pick == 1) ? FLAW_FUNC : FLAW_COUNT, data);
      end else if (pick < 72) begin
        send_frame(FLAW_CRC, data);
      end else if (pick < 80) begin
        // skip timeouts that would take tens of thousands of ticks
        send_frame((cur_gap <= 16'd400) ? FLAW_SHORT : FLAW_NONE, data);
      end else if (pick < 88) begin
        send_frame(FLAW_RESTART, data);
      end else begin
        // stray words of any kind, mostly with no frame open
        repeat ($urandom_range(1, 4)) put_word(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
      end
    end
  endtask

  // Receiver: a hold-off, when asked for, is counted down here one cycle at
  // a time; otherwise drop ready at random while idling is on.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(0, 99) < 19);
      end
    end
  end

  initial begin
    logic [DATA_BYTES-1:0][7:0] data;

    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_START;
    in_ch.data_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_SLAVE_ADDRESS;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 7; ph++) begin
      // Phase 0 runs on the reset values; every later phase rewrites all three
      case (ph)
        0: ;
        1: load_settings(8'h00, 8'h00, 16'd1);
        2: load_settings(8'hFF, 8'hFF, 16'd0);
        3: load_settings(8'($urandom), 8'($urandom), 16'd3);
        4: load_settings(8'($urandom), 8'($urandom), 16'hFFFF);
        5: load_settings(8'($urandom), 8'($urandom), 16'($urandom_range(2, 12)));
        default: load_settings(8'($urandom), 8'($urandom), 16'd400);
      endcase

      // Phase 2 is the stretch with no idling on either side
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);

      case (ph)
        0: begin
          // Ignored words first: tick and byte with no frame open, unknown kind
          put_word(KIND_TICK, 8'h00);
          put_word(KIND_BYTE, 8'hFF);
          put_word(KIND_UNUSED, 8'hA5);
          // An empty frame, dropped without a verdict by the next start
          put_word(KIND_START, 8'h00);
          // Valid frame whose data words swing between all ones and all zeros
          for (int i = 0; i < DATA_BYTES; i++) data[i] = i[1] ? 8'h00 : 8'hFF;
          send_frame(FLAW_NONE, data);
        end
        1: begin
          // Hold the receiver off while timeouts pile up: with a gap limit of
          // one, every start and tick pair yields a verdict, so the block
          // fills and must stall its input. Then pause until all are out.
          hold_left = 200;
          repeat (40) begin
            put_word(KIND_START, 8'($urandom));
            put_word(KIND_TICK, 8'($urandom));
          end
          drain();
        end
        default: ;
      endcase

      run_random(PHASE_WORDS);
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost verdict ends the run here
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/mrc_pkg.sv
rtl/core/mrc_in_if.sv
rtl/core/mrc_out_if.sv
rtl/core/mrc_frame.sv
rtl/core/modbus_response_checker.sv
bench/mrc_verdict_monitor.sv
bench/modbus_response_checker_tb.sv
